// ===== hw/rtl/psv_pkg.sv =====
// ----------------------------------------------------------------------------
// psv_pkg
// Shared types and constants of the plucked string voice: register map,
// reset values, item codes, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
package psv_pkg;

   // configuration register widths
   localparam int PERIOD_W = 12;
   localparam int GAIN_W   = 16;
   localparam int ALEN_W   = 12;
   localparam int STEP_W   = 16;
   localparam int RAMP_W   = ALEN_W + STEP_W;

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_PERIOD_LENGTH = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_DECAY_GAIN    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_ATTACK_LENGTH = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_ATTACK_STEP   = 2'd3;

   localparam logic [PERIOD_W-1:0] PERIOD_LENGTH_RST = 12'd100;
   localparam logic [GAIN_W-1:0]   DECAY_GAIN_RST    = 16'd65274;
   localparam logic [ALEN_W-1:0]   ATTACK_LENGTH_RST = 12'd220;
   localparam logic [STEP_W-1:0]   ATTACK_STEP_RST   = 16'd298;

   // item codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_DECAY
   } state_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period_length;
      logic [GAIN_W-1:0]   decay_gain;
      logic [ALEN_W-1:0]   attack_length;
      logic [STEP_W-1:0]   attack_step;
   } csr_regs_type;

   typedef struct packed {
      logic push;
      logic apply;
   } ramp_cmd_type;

endpackage

// ===== hw/rtl/psv_csr.sv =====
// ----------------------------------------------------------------------------
// psv_csr
// Configuration registers behind a simple APB-style slave, zero wait states.
// ----------------------------------------------------------------------------
module psv_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [psv_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [psv_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [psv_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output psv_pkg::csr_regs_type               regs
);

   psv_pkg::csr_regs_type regs_ff;
   logic [psv_pkg::REG_IDX_W-1:0] idx;
   logic wr_en;

   assign pready = 1'b1;
   assign idx    = paddr[psv_pkg::CSR_ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite & pready;
   assign regs   = regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.period_length <= psv_pkg::PERIOD_LENGTH_RST;
         regs_ff.decay_gain    <= psv_pkg::DECAY_GAIN_RST;
         regs_ff.attack_length <= psv_pkg::ATTACK_LENGTH_RST;
         regs_ff.attack_step   <= psv_pkg::ATTACK_STEP_RST;
      end else if (wr_en) begin
         case (idx)
            psv_pkg::REG_PERIOD_LENGTH: begin
               regs_ff.period_length <= pwdata[psv_pkg::PERIOD_W-1:0];
            end
            psv_pkg::REG_DECAY_GAIN: begin
               regs_ff.decay_gain <= pwdata[psv_pkg::GAIN_W-1:0];
            end
            psv_pkg::REG_ATTACK_LENGTH: begin
               regs_ff.attack_length <= pwdata[psv_pkg::ALEN_W-1:0];
            end
            psv_pkg::REG_ATTACK_STEP: begin
               regs_ff.attack_step <= pwdata[psv_pkg::STEP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         psv_pkg::REG_PERIOD_LENGTH: begin
            prdata = psv_pkg::CSR_DATA_W'(regs_ff.period_length);
         end
         psv_pkg::REG_DECAY_GAIN: begin
            prdata = psv_pkg::CSR_DATA_W'(regs_ff.decay_gain);
         end
         psv_pkg::REG_ATTACK_LENGTH: begin
            prdata = psv_pkg::CSR_DATA_W'(regs_ff.attack_length);
         end
         psv_pkg::REG_ATTACK_STEP: begin
            prdata = psv_pkg::CSR_DATA_W'(regs_ff.attack_step);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/psv_ring.sv =====
// ----------------------------------------------------------------------------
// psv_ring
// String delay line: synchronous RAM, one write port, two registered reads.
// ----------------------------------------------------------------------------
module psv_ring #(
   parameter int DEPTH = 2048,
   parameter int DW    = 16,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] wa,
   input  logic [DW-1:0] wd,
   input  logic          re,
   input  logic [AW-1:0] ra0,
   input  logic [AW-1:0] ra1,
   output logic [DW-1:0] rd0,
   output logic [DW-1:0] rd1
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd0_ff;
   logic [DW-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd0_ff <= mem[ra0];
         rd1_ff <= mem[ra1];
      end
   end

   assign rd0 = rd0_ff;
   assign rd1 = rd1_ff;

endmodule

// ===== hw/rtl/psv_ctrl.sv =====
// ----------------------------------------------------------------------------
// psv_ctrl
// Sequencer: ring addressing, read-modify-write of the string loop with the
// decay filter, and the attack counter.
// ----------------------------------------------------------------------------
module psv_ctrl #(
   parameter int MAX_PERIOD  = 2048,
   parameter int SAMPLE_BITS = 16,
   parameter int AW          = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  psv_pkg::csr_regs_type             regs,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic signed [SAMPLE_BITS-1:0]     req_excitation,
   input  logic                              ramp_free,
   output psv_pkg::ramp_cmd_type             ramp_cmd,
   output logic signed [SAMPLE_BITS-1:0]     decay_sample,
   output logic [psv_pkg::RAMP_W-1:0]        ramp_gain,
   output logic                              mem_we,
   output logic [AW-1:0]                     mem_wa,
   output logic [SAMPLE_BITS-1:0]            mem_wd,
   output logic                              mem_re,
   output logic [AW-1:0]                     mem_ra0,
   output logic [AW-1:0]                     mem_ra1,
   input  logic [SAMPLE_BITS-1:0]            mem_rd0,
   input  logic [SAMPLE_BITS-1:0]            mem_rd1
);

   localparam int EW = (psv_pkg::PERIOD_W > AW + 1) ? psv_pkg::PERIOD_W : AW + 1;
   localparam int SB = SAMPLE_BITS;

   psv_pkg::state_type state_ff, state_in;
   logic [AW-1:0] play_ff, play_in;
   logic [AW-1:0] load_ff, load_in;
   logic [psv_pkg::ALEN_W-1:0] count_ff, count_in;
   logic [AW-1:0] wa_ff;
   logic [psv_pkg::RAMP_W-1:0] gain_ff;
   logic apply_ff;

   logic [EW-1:0] period_ext;
   logic [EW-1:0] eff_period;
   logic [AW-1:0] play_cur, play_nxt;
   logic [AW-1:0] load_cur, load_nxt;
   logic [EW-1:0] play_inc, load_inc;
   logic accept, accept_tick, accept_load;
   logic attack_on;

   logic signed [SB:0]    pair_sum;
   logic signed [SB-1:0]  pair_avg;
   logic signed [SB+16:0] decay_prod;

   // period clamped to the legal ring range
   always_comb begin
      period_ext = EW'(regs.period_length);
      if (period_ext < EW'(2)) begin
         eff_period = EW'(2);
      end else if (period_ext > EW'(MAX_PERIOD)) begin
         eff_period = EW'(MAX_PERIOD);
      end else begin
         eff_period = period_ext;
      end
   end

   // positions beyond a shrunken period restart at zero
   always_comb begin
      play_cur = (EW'(play_ff) >= eff_period) ? '0 : play_ff;
      play_inc = EW'(play_cur) + EW'(1);
      play_nxt = (play_inc >= eff_period) ? '0 : play_inc[AW-1:0];
      load_cur = (EW'(load_ff) >= eff_period) ? '0 : load_ff;
      load_inc = EW'(load_cur) + EW'(1);
      load_nxt = (load_inc >= eff_period) ? '0 : load_inc[AW-1:0];
   end

   assign attack_on = count_ff < regs.attack_length;

   // loop filter on the registered ring words
   always_comb begin
      pair_sum   = $signed({mem_rd0[SB-1], mem_rd0}) + $signed({mem_rd1[SB-1], mem_rd1});
      pair_avg   = pair_sum[SB:1];
      decay_prod = pair_avg * $signed({1'b0, regs.decay_gain});
   end

   assign decay_sample = decay_prod[SB+15:16];
   assign ramp_gain    = gain_ff;
   assign mem_ra0      = play_cur;
   assign mem_ra1      = play_nxt;

   always_comb begin
      state_in      = state_ff;
      play_in       = play_ff;
      load_in       = load_ff;
      count_in      = count_ff;
      req_ready     = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = wa_ff;
      mem_wd        = decay_sample;
      mem_re        = 1'b0;
      ramp_cmd.push  = 1'b0;
      ramp_cmd.apply = apply_ff;
      accept        = 1'b0;
      accept_tick   = 1'b0;
      accept_load   = 1'b0;
      case (state_ff)
         psv_pkg::ST_IDLE: begin
            req_ready   = ramp_free;
            accept      = req_valid & ramp_free;
            accept_tick = accept & (req_func == psv_pkg::FUNC_TICK);
            accept_load = accept & (req_func == psv_pkg::FUNC_LOAD);
            if (accept_load) begin
               mem_we   = 1'b1;
               mem_wa   = load_cur;
               mem_wd   = req_excitation;
               load_in  = load_nxt;
               play_in  = '0;
               count_in = '0;
            end
            if (accept_tick) begin
               mem_re   = 1'b1;
               play_in  = play_nxt;
               load_in  = '0;
               if (attack_on) begin
                  count_in = count_ff + psv_pkg::ALEN_W'(1);
               end
               state_in = psv_pkg::ST_DECAY;
            end
         end
         psv_pkg::ST_DECAY: begin
            // write back the filtered word and hand it to the ramp stage
            mem_we        = 1'b1;
            ramp_cmd.push = 1'b1;
            state_in      = psv_pkg::ST_IDLE;
         end
         default: begin
            state_in = psv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psv_pkg::ST_IDLE;
         play_ff  <= '0;
         load_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         play_ff  <= play_in;
         load_ff  <= load_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_tick) begin
         wa_ff    <= play_cur;
         apply_ff <= attack_on;
         gain_ff  <= count_ff * regs.attack_step;
      end
   end

endmodule

// ===== hw/rtl/psv_ramp.sv =====
// ----------------------------------------------------------------------------
// psv_ramp
// Attack ramp stage with saturation, followed by the result register.
// ----------------------------------------------------------------------------
module psv_ramp #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  psv_pkg::ramp_cmd_type          cmd,
   input  logic signed [SAMPLE_BITS-1:0]  in_sample,
   input  logic [psv_pkg::RAMP_W-1:0]     in_gain,
   output logic                           ramp_free,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]  rsp_sample
);

   localparam int SB = SAMPLE_BITS;
   localparam int PW = SB + psv_pkg::RAMP_W + 1;
   localparam int WW = PW - 16;

   logic rv_ff, rv_in;
   logic ov_ff, ov_in;
   logic apply_ff;
   logic signed [SB-1:0] rs_ff;
   logic [psv_pkg::RAMP_W-1:0] rg_ff;
   logic signed [SB-1:0] out_ff;

   logic move;
   logic signed [PW-1:0] prod;
   logic signed [WW-1:0] wide;
   logic overflow;
   logic signed [SB-1:0] ramped;

   assign move      = rv_ff & (~ov_ff | rsp_ready);
   assign ramp_free = ~rv_ff | move;

   always_comb begin
      prod = rs_ff * $signed({1'b0, rg_ff});
      wide = prod[PW-1:16];
      // bits above the sample's sign must all match the sign
      overflow = (wide[WW-1:SB-1] != {(WW-SB+1){1'b0}})
              && (wide[WW-1:SB-1] != {(WW-SB+1){1'b1}});
      if (overflow) begin
         ramped = wide[WW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end else begin
         ramped = wide[SB-1:0];
      end
   end

   always_comb begin
      rv_in = rv_ff;
      ov_in = ov_ff;
      if (ov_ff & rsp_ready) begin
         ov_in = 1'b0;
      end
      if (move) begin
         ov_in = 1'b1;
         rv_in = 1'b0;
      end
      if (cmd.push) begin
         rv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rs_ff    <= in_sample;
         rg_ff    <= in_gain;
         apply_ff <= cmd.apply;
      end
      if (move) begin
         out_ff <= apply_ff ? ramped : rs_ff;
      end
   end

   assign rsp_valid  = ov_ff;
   assign rsp_sample = out_ff;

endmodule

// ===== hw/rtl/plucked_string_voice.sv =====
// ----------------------------------------------------------------------------
// plucked_string_voice
// Karplus-Strong plucked string voice in signed Q1.15 with decay and attack.
// ----------------------------------------------------------------------------
// A load word (func 0) writes one excitation sample into the ring; a tick
// word (func 1) has the ring read both neighbors at the accept edge, and the
// next cycle filters the pair and writes it back through the ring's single
// write port, so no word is accepted while that write-back is pending. The
// sample passes the attack ramp stage on its way to the result port. A result
// register and a ramp stage sit between the ring loop and the output, so
// the next word is taken while a result waits. The ring powers up
// unwritten and has no clear pass: load a full period before the first tick.
// ----------------------------------------------------------------------------
module plucked_string_voice #(
   parameter int MAX_PERIOD  = 2048,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic signed [SAMPLE_BITS-1:0]       req_excitation,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [psv_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [psv_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [psv_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   localparam int AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;

   psv_pkg::csr_regs_type regs;
   psv_pkg::ramp_cmd_type ramp_cmd;
   logic ramp_free;
   logic signed [SAMPLE_BITS-1:0] decay_sample;
   logic [psv_pkg::RAMP_W-1:0] ramp_gain;
   logic mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra0, mem_ra1;
   logic [SAMPLE_BITS-1:0] mem_wd, mem_rd0, mem_rd1;

   psv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .regs    (regs)
   );

   psv_ring #(
      .DEPTH (MAX_PERIOD),
      .DW    (SAMPLE_BITS),
      .AW    (AW)
   ) u_ring (
      .clock (clock),
      .we    (mem_we),
      .wa    (mem_wa),
      .wd    (mem_wd),
      .re    (mem_re),
      .ra0   (mem_ra0),
      .ra1   (mem_ra1),
      .rd0   (mem_rd0),
      .rd1   (mem_rd1)
   );

   psv_ctrl #(
      .MAX_PERIOD  (MAX_PERIOD),
      .SAMPLE_BITS (SAMPLE_BITS),
      .AW          (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .regs           (regs),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_excitation (req_excitation),
      .ramp_free      (ramp_free),
      .ramp_cmd       (ramp_cmd),
      .decay_sample   (decay_sample),
      .ramp_gain      (ramp_gain),
      .mem_we         (mem_we),
      .mem_wa         (mem_wa),
      .mem_wd         (mem_wd),
      .mem_re         (mem_re),
      .mem_ra0        (mem_ra0),
      .mem_ra1        (mem_ra1),
      .mem_rd0        (mem_rd0),
      .mem_rd1        (mem_rd1)
   );

   psv_ramp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ramp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ramp_cmd),
      .in_sample  (decay_sample),
      .in_gain    (ramp_gain),
      .ramp_free  (ramp_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample)
   );

   // a filtered word never lands on an occupied ramp stage
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      ramp_cmd.push |-> ramp_free)
      else $error("ramp stage overrun");

   // every accepted tick writes back in the following cycle
   a_tick_push: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == psv_pkg::FUNC_TICK) |=> ramp_cmd.push)
      else $error("tick without write-back");

   // a load never produces a result
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == psv_pkg::FUNC_LOAD) |=> !ramp_cmd.push)
      else $error("load produced a result");

   // write-back and a new ring read never share a cycle
   a_rmw_interlock: assert property (@(posedge clock) disable iff (reset)
      ramp_cmd.push |-> !req_ready)
      else $error("ring access overlap");

endmodule

// ===== dv/tb_plucked_string_voice.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_plucked_string_voice
// Self-checking bench for the plucked string voice: a shadow of the string
// ring, positions, attack counter and registers predicts every output
// sample from the accepted words, under bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb_plucked_string_voice;

   localparam int MAX_PERIOD    = 2048;
   localparam int RANDOM_WORDS  = 500;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 10;
   localparam int CYCLE_LIMIT   = 1000000;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic                             req_func;
   logic signed [15:0]               req_excitation;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic signed [15:0]               rsp_sample;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [psv_pkg::CSR_ADDR_W-1:0]   paddr;
   logic [psv_pkg::CSR_DATA_W-1:0]   pwdata;
   logic [psv_pkg::CSR_DATA_W-1:0]   prdata;
   logic                             pready;

   plucked_string_voice dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_excitation (req_excitation),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample     (rsp_sample),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the voice
   logic signed [15:0]           ring_model [0:MAX_PERIOD-1];
   bit                           ring_written [0:MAX_PERIOD-1];
   int unsigned                  play_pos;
   int unsigned                  load_pos;
   int unsigned                  attack_cnt;
   logic [psv_pkg::PERIOD_W-1:0] period_reg;
   logic [psv_pkg::GAIN_W-1:0]   decay_reg;
   logic [psv_pkg::ALEN_W-1:0]   attack_len_reg;
   logic [psv_pkg::STEP_W-1:0]   step_reg;

   logic signed [15:0]  expected_samples [$];
   logic signed [15:0]  oldest_sample;

   int errors;
   int loads_sent;
   int ticks_sent;
   int samples_checked;
   int saturations;
   int settings_applied;
   int widest_span;
   int cycle_count;

   // sender bursts
   bit gaps_enabled;
   int burst_left;

   // sink stall pattern and long hold-off
   logic        hold_request;
   int          hold_left;
   logic [7:0]  stall_phase;
   int unsigned stall_mode;
   logic [15:0] stall_bits;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d samples outstanding", cycle_count,
                  expected_samples.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         rsp_ready    <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         hold_request <= 1'b0;
      end else begin
         if (stall_phase[5:0] == 6'd0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_bits <= 16'($urandom) | 16'h0101;
         end
         stall_phase <= stall_phase + 1'b1;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= stall_bits[stall_phase[3:0]];
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $error("sample: expected none, actual %0d", rsp_sample);
            errors++;
         end else begin
            oldest_sample = expected_samples.pop_front();
            samples_checked++;
            if (rsp_sample !== oldest_sample) begin
               $error("sample: expected %0d, actual %0d", oldest_sample, rsp_sample);
               errors++;
            end
         end
      end
   end

   function automatic int unsigned string_span();
      int unsigned p;
      p = period_reg;
      if (p < 2) p = 2;
      if (p > MAX_PERIOD) p = MAX_PERIOD;
      return p;
   endfunction

   // a tick must never read a ring entry that no load has written
   function automatic bit tick_reads_written();
      int unsigned span;
      int unsigned here;
      int unsigned there;
      span  = string_span();
      here  = (play_pos < span) ? play_pos : 0;
      there = (here + 1 >= span) ? 0 : here + 1;
      return ring_written[here] && ring_written[there];
   endfunction

   function automatic logic signed [15:0] clip_sample(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic [15:0] pick_excitation();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($signed($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic advance_voice(input logic func, input logic [15:0] exc);
      int unsigned span;
      int unsigned here;
      int unsigned there;
      longint avg;
      longint filt;
      longint gain;
      span = string_span();
      if (span > widest_span) widest_span = span;
      if (func == psv_pkg::FUNC_LOAD) begin
         here = (load_pos < span) ? load_pos : 0;
         ring_model[here]   = exc;
         ring_written[here] = 1'b1;
         here++;
         load_pos   = (here >= span) ? 0 : here;
         play_pos   = 0;
         attack_cnt = 0;
         loads_sent++;
      end else begin
         here  = (play_pos < span) ? play_pos : 0;
         there = (here + 1 >= span) ? 0 : here + 1;
         avg   = (longint'(ring_model[here]) + longint'(ring_model[there])) >>> 1;
         filt  = (longint'(decay_reg) * avg) >>> 16;
         ring_model[here] = filt[15:0];
         play_pos = there;
         load_pos = 0;
         if (attack_cnt < attack_len_reg) begin
            gain = longint'(attack_cnt) * longint'(step_reg);
            filt = (filt * gain) >>> 16;
            if (filt > 32767 || filt < -32768) saturations++;
            filt = clip_sample(filt);
            attack_cnt++;
         end
         expected_samples.insert(expected_samples.size(), filt[15:0]);
         ticks_sent++;
      end
   endtask

   task automatic send_word(input logic func, input logic [15:0] exc);
      if (gaps_enabled && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left != 0) burst_left--;
      req_valid      <= 1'b1;
      req_func       <= func;
      req_excitation <= exc;
      do @(posedge clock); while (!req_ready);
      advance_voice(func, exc);
   endtask

   task automatic pluck(input int unsigned count);
      repeat (count) send_word(psv_pkg::FUNC_LOAD, pick_excitation());
   endtask

   // ticks that would read unwritten entries, and with noise set a random share of the others, become loads instead
   task automatic tick_run(input int unsigned count, input int unsigned noise);
      repeat (count) begin
         if (!tick_reads_written() || (noise != 0 && $urandom_range(1, noise) == 1))
            send_word(psv_pkg::FUNC_LOAD, pick_excitation());
         else
            send_word(psv_pkg::FUNC_TICK, 16'($urandom));
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [psv_pkg::REG_IDX_W-1:0] idx,
                            input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         psv_pkg::REG_PERIOD_LENGTH: period_reg     = value[psv_pkg::PERIOD_W-1:0];
         psv_pkg::REG_DECAY_GAIN:    decay_reg      = value[psv_pkg::GAIN_W-1:0];
         psv_pkg::REG_ATTACK_LENGTH: attack_len_reg = value[psv_pkg::ALEN_W-1:0];
         psv_pkg::REG_ATTACK_STEP:   step_reg       = value[psv_pkg::STEP_W-1:0];
         default: ;
      endcase
      settings_applied++;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_reg(input logic [psv_pkg::REG_IDX_W-1:0] idx,
                            input logic [31:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         $error("register %0d: expected %0d, actual %0d", idx, want, prdata);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_values();
      check_reg(psv_pkg::REG_PERIOD_LENGTH, 32'(psv_pkg::PERIOD_LENGTH_RST));
      check_reg(psv_pkg::REG_DECAY_GAIN, 32'(psv_pkg::DECAY_GAIN_RST));
      check_reg(psv_pkg::REG_ATTACK_LENGTH, 32'(psv_pkg::ATTACK_LENGTH_RST));
      check_reg(psv_pkg::REG_ATTACK_STEP, 32'(psv_pkg::ATTACK_STEP_RST));
      send_word(psv_pkg::FUNC_LOAD, 16'h7fff);
      send_word(psv_pkg::FUNC_LOAD, 16'h8000);
      send_word(psv_pkg::FUNC_LOAD, 16'hffff);
      send_word(psv_pkg::FUNC_TICK, 16'h0000);
      send_word(psv_pkg::FUNC_TICK, 16'hffff);
      wait_idle();
   endtask

   // period below two is taken as two; zero decay silences the loop
   task automatic test_period_clamp();
      write_reg(psv_pkg::REG_PERIOD_LENGTH, 32'd0);
      write_reg(psv_pkg::REG_DECAY_GAIN, 32'd65535);
      write_reg(psv_pkg::REG_ATTACK_LENGTH, 32'd0);
      check_reg(psv_pkg::REG_PERIOD_LENGTH, 32'd0);
      send_word(psv_pkg::FUNC_LOAD, 16'h7fff);
      send_word(psv_pkg::FUNC_LOAD, 16'h8000);
      send_word(psv_pkg::FUNC_TICK, 16'h0000);
      send_word(psv_pkg::FUNC_TICK, 16'h0000);
      wait_idle();
      write_reg(psv_pkg::REG_PERIOD_LENGTH, 32'd1);
      write_reg(psv_pkg::REG_DECAY_GAIN, 32'd0);
      send_word(psv_pkg::FUNC_TICK, 16'h0000);
      wait_idle();
   endtask

   // ramp gain above one must clip to full scale
   task automatic test_attack_saturation();
      write_reg(psv_pkg::REG_PERIOD_LENGTH, 32'd2);
      write_reg(psv_pkg::REG_DECAY_GAIN, 32'd65535);
      write_reg(psv_pkg::REG_ATTACK_LENGTH, 32'd4095);
      write_reg(psv_pkg::REG_ATTACK_STEP, 32'd65535);
      check_reg(psv_pkg::REG_ATTACK_STEP, 32'd65535);
      send_word(psv_pkg::FUNC_LOAD, 16'h7fff);
      send_word(psv_pkg::FUNC_LOAD, 16'h7fff);
      tick_run(3, 0);
      send_word(psv_pkg::FUNC_LOAD, 16'h8000);
      send_word(psv_pkg::FUNC_LOAD, 16'h8000);
      tick_run(3, 0);
      wait_idle();
   endtask

   // play position past a shrunken period restarts at zero, and a lowered
   // attack length ends the ramp at once
   task automatic test_period_shrink();
      write_reg(psv_pkg::REG_PERIOD_LENGTH, 32'd4);
      write_reg(psv_pkg::REG_DECAY_GAIN, 32'd65000);
      write_reg(psv_pkg::REG_ATTACK_LENGTH, 32'd10);
      write_reg(psv_pkg::REG_ATTACK_STEP, 32'd6000);
      pluck(4);
      tick_run(3, 0);
      wait_idle();
      write_reg(psv_pkg::REG_PERIOD_LENGTH, 32'd2);
      write_reg(psv_pkg::REG_ATTACK_LENGTH, 32'd1);
      tick_run(2, 0);
      wait_idle();
   endtask

   // period above the ring size is clamped down to the maximum
   task automatic test_longest_string();
      gaps_enabled = 1'b0;
      write_reg(psv_pkg::REG_PERIOD_LENGTH, 32'd4095);
      write_reg(psv_pkg::REG_DECAY_GAIN, 32'd65535);
      write_reg(psv_pkg::REG_ATTACK_LENGTH, 32'd0);
      pluck(40);
      tick_run(30, 0);
      wait_idle();
      gaps_enabled = 1'b1;
   endtask

   task automatic test_output_backpressure();
      gaps_enabled = 1'b0;
      write_reg(psv_pkg::REG_PERIOD_LENGTH, 32'd16);
      write_reg(psv_pkg::REG_DECAY_GAIN, 32'd64000);
      write_reg(psv_pkg::REG_ATTACK_LENGTH, 32'd20);
      write_reg(psv_pkg::REG_ATTACK_STEP, 32'd3300);
      pluck(16);
      hold_request <= 1'b1;
      tick_run(80, 0);
      wait_idle();
      gaps_enabled = 1'b1;
   endtask

   task automatic reconfigure_randomly();
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 9))
            0: write_reg(psv_pkg::REG_PERIOD_LENGTH, $urandom_range(0, 3));
            1: write_reg(psv_pkg::REG_PERIOD_LENGTH, $urandom_range(MAX_PERIOD - 8, 4095));
            2, 3: write_reg(psv_pkg::REG_PERIOD_LENGTH, $urandom_range(17, 96));
            default: write_reg(psv_pkg::REG_PERIOD_LENGTH, $urandom_range(2, 16));
         endcase
      end
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 5))
            0: write_reg(psv_pkg::REG_DECAY_GAIN, 32'd0);
            1: write_reg(psv_pkg::REG_DECAY_GAIN, 32'd65535);
            2: write_reg(psv_pkg::REG_DECAY_GAIN, $urandom_range(0, 65535));
            default: write_reg(psv_pkg::REG_DECAY_GAIN, $urandom_range(60000, 65535));
         endcase
      end
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 5))
            0: write_reg(psv_pkg::REG_ATTACK_LENGTH, 32'd0);
            1: write_reg(psv_pkg::REG_ATTACK_LENGTH, 32'd4095);
            default: write_reg(psv_pkg::REG_ATTACK_LENGTH, $urandom_range(0, 40));
         endcase
      end
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 5))
            0: write_reg(psv_pkg::REG_ATTACK_STEP, 32'd0);
            1: write_reg(psv_pkg::REG_ATTACK_STEP, 32'd65535);
            2: write_reg(psv_pkg::REG_ATTACK_STEP, $urandom_range(0, 65535));
            default: write_reg(psv_pkg::REG_ATTACK_STEP, $urandom_range(1, 8000));
         endcase
      end
   endtask

   // mostly whole plucks followed by tick runs, with stray loads and
   // partial plucks mixed in
   task automatic test_random_phases();
      int first_word;
      int unsigned span;
      int unsigned fill;
      first_word = loads_sent + ticks_sent;
      while (loads_sent + ticks_sent - first_word < RANDOM_WORDS) begin
         reconfigure_randomly();
         gaps_enabled = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 3)) begin
            span = string_span();
            fill = (span > 80) ? 80 : span;
            if ($urandom_range(0, 3) == 0) fill = $urandom_range(1, fill);
            pluck(fill);
            tick_run($urandom_range(4, 60), 16);
         end
         wait_idle();
      end
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = psv_pkg::FUNC_LOAD;
      req_excitation = '0;
      rsp_ready      = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      hold_request   = 1'b0;
      hold_left      = 0;
      stall_phase    = '0;
      stall_mode     = 0;
      stall_bits     = 16'hffff;
      cycle_count    = 0;
      gaps_enabled   = 1'b1;
      burst_left     = 0;
      period_reg     = psv_pkg::PERIOD_LENGTH_RST;
      decay_reg      = psv_pkg::DECAY_GAIN_RST;
      attack_len_reg = psv_pkg::ATTACK_LENGTH_RST;
      step_reg       = psv_pkg::ATTACK_STEP_RST;
      play_pos       = 0;
      load_pos       = 0;
      attack_cnt     = 0;
      foreach (ring_model[i]) begin
         ring_model[i]   = '0;
         ring_written[i] = 1'b0;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_period_clamp();
      test_attack_saturation();
      test_period_shrink();
      test_longest_string();
      test_output_backpressure();
      test_random_phases();
      wait_idle();

      $display("covered %0d loads and %0d ticks, %0d samples checked, %0d clipped by the ramp",
               loads_sent, ticks_sent, samples_checked, saturations);
      $display("%0d register writes, ring lengths up to %0d", settings_applied, widest_span);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== plucked_string_voice.f =====
hw/rtl/psv_pkg.sv
hw/rtl/psv_csr.sv
hw/rtl/psv_ring.sv
hw/rtl/psv_ctrl.sv
hw/rtl/psv_ramp.sv
hw/rtl/plucked_string_voice.sv
dv/tb_plucked_string_voice.sv
